// ----- hdl/pcc_pkg.sv -----
package pcc_pkg;

    localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
    localparam int          CRC_W     = 32;
    localparam int          COUNT_W   = 64;
    localparam int          BYTE_W    = 8;

    // Step addresses of the control program.
    typedef enum logic [1:0] {
        STEP_TAKE = 2'd0,
        STEP_TAIL = 2'd1,
        STEP_EMIT = 2'd2
    } step_t;

    // Source of the byte folded into the CRC in a step.
    typedef enum logic [1:0] {
        FOLD_NONE = 2'd0,
        FOLD_DATA = 2'd1,
        FOLD_TAIL = 2'd2
    } fold_src_t;

    // Condition that selects between the two successor steps.
    typedef enum logic [1:0] {
        COND_LAST      = 2'd0,
        COND_TAIL_ZERO = 2'd1,
        COND_OUT_FREE  = 2'd2
    } cond_t;

    typedef struct packed {
        logic      accept;
        fold_src_t fold_src;
        logic      load_tail;
        logic      emit;
        cond_t     cond;
        step_t     pass_step;
        step_t     fail_step;
    } ctrl_word_t;

    // Control store. The tail step folds one length byte per cycle until the
    // remaining count is zero; the emit step waits for the output register.
    function automatic ctrl_word_t uc_rom(input step_t step);
        ctrl_word_t w;
        case (step)
            STEP_TAKE: w = '{accept: 1'b1, fold_src: FOLD_DATA, load_tail: 1'b1,
                             emit: 1'b0, cond: COND_LAST,
                             pass_step: STEP_TAIL, fail_step: STEP_TAKE};
            STEP_TAIL: w = '{accept: 1'b0, fold_src: FOLD_TAIL, load_tail: 1'b0,
                             emit: 1'b0, cond: COND_TAIL_ZERO,
                             pass_step: STEP_EMIT, fail_step: STEP_TAIL};
            STEP_EMIT: w = '{accept: 1'b0, fold_src: FOLD_NONE, load_tail: 1'b0,
                             emit: 1'b1, cond: COND_OUT_FREE,
                             pass_step: STEP_TAKE, fail_step: STEP_EMIT};
            default:   w = '{accept: 1'b0, fold_src: FOLD_NONE, load_tail: 1'b0,
                             emit: 1'b0, cond: COND_LAST,
                             pass_step: STEP_TAKE, fail_step: STEP_TAKE};
        endcase
        return w;
    endfunction

    // One byte into a non-reflected CRC-32, most significant bit first.
    function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc_in,
                                                       input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/pcc_if.sv -----
interface pcc_msg_if;
    logic                          valid;
    logic                          ready;
    logic [pcc_pkg::BYTE_W-1:0]    data_byte;
    logic                          byte_present;
    logic                          last_item;
    logic [pcc_pkg::CRC_W-1:0]     expected_sum;

    modport source (output valid, output data_byte, output byte_present,
                    output last_item, output expected_sum, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input last_item, input expected_sum, output ready);
endinterface

interface pcc_result_if;
    logic                          valid;
    logic                          ready;
    logic [pcc_pkg::CRC_W-1:0]     checksum;
    logic                          sum_matches;

    modport source (output valid, output checksum, output sum_matches, input ready);
    modport sink   (input valid, input checksum, input sum_matches, output ready);
endinterface

// ----- hdl/posix_cksum_crc32_engine.sv -----
// Channel   Dir   Payload                                           Transfer
// msg       in    data_byte, byte_present, last_item, expected_sum  valid & ready
// result    out   checksum, sum_matches                             valid & ready
//
// Items are accepted back to back until the last one. After the last item the
// length tail folds in the significant bytes of the byte count (0 to 8), low
// byte first, and the emit step then loads the output register.
// The tail loops through the single byte-wide CRC fold unit.
// Reset clears the step counter, the CRC, the byte count and the output valid.
// A stalled result blocks the next message only once its own result is ready.
module posix_cksum_crc32_engine (
    input  logic         clk,
    input  logic         rst_n,
    pcc_msg_if.sink      msg,
    pcc_result_if.source result
);

    pcc_pkg::step_t                 pc_reg, pc_next;
    pcc_pkg::ctrl_word_t            word;
    logic [pcc_pkg::CRC_W-1:0]      crc_reg, crc_next, crc_folded;
    logic [pcc_pkg::COUNT_W-1:0]    count_reg, count_next, count_inc;
    logic [pcc_pkg::COUNT_W-1:0]    tail_reg, tail_next;
    logic [pcc_pkg::CRC_W-1:0]      expected_reg, expected_next;
    logic [pcc_pkg::CRC_W-1:0]      checksum_reg, checksum_next;
    logic                           match_reg, match_next;
    logic                           out_valid_reg, out_valid_next;
    logic [pcc_pkg::BYTE_W-1:0]     fold_byte;
    logic                           fold_en;
    logic                           msg_xfer;
    logic                           tail_zero;
    logic                           out_free;
    logic                           cond_met;
    logic                           do_emit;

    assign word      = pcc_pkg::uc_rom(pc_reg);
    assign msg_xfer  = msg.valid & word.accept;
    assign tail_zero = (tail_reg == '0);
    assign out_free  = ~out_valid_reg | result.ready;

    always_comb
    begin
        case (word.cond)
            pcc_pkg::COND_LAST:      cond_met = msg_xfer & msg.last_item;
            pcc_pkg::COND_TAIL_ZERO: cond_met = tail_zero;
            pcc_pkg::COND_OUT_FREE:  cond_met = out_free;
            default:                 cond_met = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = cond_met ? word.pass_step : word.fail_step;
    end

    always_comb
    begin
        case (word.fold_src)
            pcc_pkg::FOLD_DATA:
            begin
                fold_byte = msg.data_byte;
                fold_en   = msg_xfer & msg.byte_present;
            end
            pcc_pkg::FOLD_TAIL:
            begin
                fold_byte = tail_reg[pcc_pkg::BYTE_W-1:0];
                fold_en   = ~tail_zero;
            end
            default:
            begin
                fold_byte = '0;
                fold_en   = 1'b0;
            end
        endcase
    end

    assign crc_folded = pcc_pkg::crc_fold_byte(crc_reg, fold_byte);
    assign count_inc  = count_reg + pcc_pkg::COUNT_W'(1);
    assign do_emit    = word.emit & out_free;

    always_comb
    begin
        crc_next       = crc_reg;
        count_next     = count_reg;
        tail_next      = tail_reg;
        expected_next  = expected_reg;
        checksum_next  = checksum_reg;
        match_next     = match_reg;
        out_valid_next = out_valid_reg & ~result.ready;

        if (fold_en)
        begin
            crc_next = crc_folded;
        end
        if (fold_en && word.fold_src == pcc_pkg::FOLD_DATA)
        begin
            count_next = count_inc;
        end
        if (word.fold_src == pcc_pkg::FOLD_TAIL && !tail_zero)
        begin
            tail_next = tail_reg >> pcc_pkg::BYTE_W;
        end
        // The tail starts from the count including a byte carried by the last item.
        if (word.load_tail && msg_xfer && msg.last_item)
        begin
            tail_next     = count_next;
            expected_next = msg.expected_sum;
        end
        if (do_emit)
        begin
            checksum_next  = ~crc_reg;
            match_next     = (~crc_reg == expected_reg);
            out_valid_next = 1'b1;
            crc_next       = '0;
            count_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= pcc_pkg::STEP_TAKE;
            crc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg     <= tail_next;
        expected_reg <= expected_next;
        checksum_reg <= checksum_next;
        match_reg    <= match_next;
    end

    assign msg.ready          = word.accept;
    assign result.valid       = out_valid_reg;
    assign result.checksum    = checksum_reg;
    assign result.sum_matches = match_reg;

endmodule

// ----- hdl/pcc_checker.sv -----
module pcc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        msg_valid,
    input logic                        msg_ready,
    input logic                        msg_last_item,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [pcc_pkg::CRC_W-1:0]   result_checksum
);

    // A stalled result keeps its value until the transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_checksum)))
        else $error("result changed while stalled");

    // The length tail always follows the last item, so no item is taken next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && msg_ready && msg_last_item) |=> !msg_ready)
        else $error("item accepted right after the last item");

    // A new result is only produced while the input side is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!msg_ready))
        else $error("result appeared without a finishing sequence");

    // The input side waits for a free output before it opens again.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(msg_ready) |-> $past(!result_valid || result_ready))
        else $error("input reopened while the output was blocked");

endmodule

bind posix_cksum_crc32_engine pcc_checker u_pcc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .msg_valid       (msg.valid),
    .msg_ready       (msg.ready),
    .msg_last_item   (msg.last_item),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_checksum (result.checksum)
);

// ----- verif/pcc_cksum_checker.sv -----
`timescale 1ns / 1ps

module pcc_cksum_checker (
    input  logic  clk,
    input  logic  rst_n,
    pcc_msg_if    msg,
    pcc_result_if result,
    output int    fail_count,
    output int    pending
);

    typedef struct {
        logic [pcc_pkg::CRC_W-1:0] checksum;
        logic                      sum_matches;
    } cksum_result_t;

    logic [pcc_pkg::CRC_W-1:0]   running_crc;
    logic [pcc_pkg::COUNT_W-1:0] octet_count;
    cksum_result_t               sum_queue[$];

    // Shift register form: each message bit is combined with the top CRC bit.
    function automatic logic [pcc_pkg::CRC_W-1:0] cksum_fold_octet(
        input logic [pcc_pkg::CRC_W-1:0]  crc,
        input logic [pcc_pkg::BYTE_W-1:0] octet
    );
        logic [pcc_pkg::CRC_W-1:0] r;
        logic                      fb;
        r = crc;
        for (int k = pcc_pkg::BYTE_W - 1; k >= 0; k--)
        begin
            fb = r[pcc_pkg::CRC_W-1] ^ octet[k];
            r  = {r[pcc_pkg::CRC_W-2:0], 1'b0} ^ (fb ? pcc_pkg::CRC_POLY : '0);
        end
        return r;
    endfunction

    // The length goes in low byte first and stops once no set bits remain.
    function automatic logic [pcc_pkg::CRC_W-1:0] cksum_close(
        input logic [pcc_pkg::CRC_W-1:0]   crc,
        input logic [pcc_pkg::COUNT_W-1:0] count
    );
        logic [pcc_pkg::CRC_W-1:0]   r;
        logic [pcc_pkg::COUNT_W-1:0] rest;
        r    = crc;
        rest = count;
        while (rest != '0)
        begin
            r    = cksum_fold_octet(r, rest[pcc_pkg::BYTE_W-1:0]);
            rest = rest >> pcc_pkg::BYTE_W;
        end
        return ~r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cksum_result_t exp_res;
        logic [pcc_pkg::CRC_W-1:0]   crc_now;
        logic [pcc_pkg::COUNT_W-1:0] count_now;
        if (!rst_n)
        begin
            running_crc = '0;
            octet_count = '0;
            sum_queue.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (sum_queue.size() == 0)
                begin
                    report_mismatch("unexpected result checksum", result.checksum, '0);
                end
                else
                begin
                    exp_res = sum_queue.pop_front();
                    if (result.checksum !== exp_res.checksum)
                    begin
                        report_mismatch("checksum", result.checksum, exp_res.checksum);
                    end
                    if (result.sum_matches !== exp_res.sum_matches)
                    begin
                        report_mismatch("sum_matches", 32'(result.sum_matches),
                                        32'(exp_res.sum_matches));
                    end
                end
            end
            if (msg.valid && msg.ready)
            begin
                crc_now   = running_crc;
                count_now = octet_count;
                if (msg.byte_present)
                begin
                    crc_now   = cksum_fold_octet(crc_now, msg.data_byte);
                    count_now = count_now + pcc_pkg::COUNT_W'(1);
                end
                if (msg.last_item)
                begin
                    exp_res.checksum    = cksum_close(crc_now, count_now);
                    exp_res.sum_matches = (exp_res.checksum == msg.expected_sum);
                    sum_queue.push_back(exp_res);
                    crc_now   = '0;
                    count_now = '0;
                end
                running_crc = crc_now;
                octet_count = count_now;
            end
        end
        pending = sum_queue.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int ITEM_TARGET = 1900;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   items_sent;
    bit   msg_burst;
    bit   res_burst;

    pcc_msg_if    msg_if ();
    pcc_result_if res_if ();

    posix_cksum_crc32_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .result (res_if)
    );

    pcc_cksum_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg_if),
        .result     (res_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // One transfer on the message channel, after a random gap unless bursting.
    task automatic send_item(input logic [7:0] d, input logic p, input logic l,
                             input logic [31:0] e);
        int gap;
        gap = msg_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid        <= 1'b1;
        msg_if.data_byte    <= d;
        msg_if.byte_present <= p;
        msg_if.last_item    <= l;
        msg_if.expected_sum <= e;
        do @(posedge clk); while (!msg_if.ready);
        items_sent++;
    endtask

    // Body items mostly carry a byte; now and then one carries none.
    task automatic send_random_msg(input int body_len, input logic [31:0] e);
        for (int i = 0; i < body_len; i++)
        begin
            send_item(8'($urandom), $urandom_range(0, 7) != 0, 1'b0, $urandom);
        end
        send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1, e);
    endtask

    initial
    begin
        int pick;
        msg_if.valid        <= 1'b0;
        msg_if.data_byte    <= '0;
        msg_if.byte_present <= 1'b0;
        msg_if.last_item    <= 1'b0;
        msg_if.expected_sum <= '0;
        rst_n               <= 1'b0;
        items_sent = 0;
        msg_burst  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty messages: the checksum of nothing is all ones.
        send_item(8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF);
        send_item(8'h00, 1'b0, 1'b1, 32'h0000_0000);
        // Single byte carried on the last item, both data extremes.
        send_item(8'h00, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_item(8'hFF, 1'b1, 1'b1, 32'h0000_0000);
        // The classic check string.
        msg_burst = 1'b1;
        for (int c = 8'h31; c < 8'h39; c++)
        begin
            send_item(c[7:0], 1'b1, 1'b0, 32'h0);
        end
        send_item(8'h39, 1'b1, 1'b1, 32'h377A_6011);
        msg_burst = 1'b0;
        // Item without a byte inside a message, then an empty final item.
        send_item(8'hA5, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_item(8'h3C, 1'b0, 1'b0, 32'h5555_AAAA);
        send_item(8'h5A, 1'b1, 1'b0, 32'hAAAA_5555);
        send_item(8'hC3, 1'b0, 1'b1, 32'h0000_0000);

        // A count above 255 needs two bytes of length tail.
        msg_burst = 1'b1;
        send_random_msg(300, $urandom);

        while (items_sent < ITEM_TARGET)
        begin
            msg_burst = ($urandom_range(0, 3) == 0);
            pick      = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_item(8'($urandom), 1'b0, 1'b1,
                          $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom);
            end
            else if (pick < 9)
            begin
                send_random_msg($urandom_range(255, 280), $urandom);
            end
            else
            begin
                send_random_msg($urandom_range(0, 24), $urandom);
            end
        end
        msg_if.valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Result side: random stall before each transfer, with bursts of no stall.
    initial
    begin
        int gap;
        int taken;
        res_if.ready <= 1'b0;
        res_burst = 1'b0;
        taken     = 0;
        @(posedge rst_n);
        forever
        begin
            gap = res_burst ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            taken++;
            if (taken % 12 == 0)
            begin
                res_burst = ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/pcc_pkg.sv
hdl/pcc_if.sv
hdl/posix_cksum_crc32_engine.sv
hdl/pcc_checker.sv
verif/pcc_cksum_checker.sv
verif/tb_top.sv
